/* hw/rtl/ple_pkg.sv */
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int OP_W     = 3;

    localparam int IN_BITS   = OP_W + POS_W + DATA_W;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + DATA_W + LEN_W + LEN_W + 1;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_DEL,
        ST_LOC,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/positional_list_engine_core.sv */
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit elements in a single-port-write,
// registered-read store, driven by a small sequencer that moves one element per
// cycle. One item is taken at a time; the input is ready only while the sequencer
// is idle. Insert, delete and get walk n = length - position + 1 entries, the
// number of entries moved or read (one for get), except that an insert at the end
// of the list moves none. Locate walks n entries, compared up to the first match
// or the whole list. Clear and any request that fails its checks go straight to
// the result. The sequencer is idle again as the result appears, so the next item
// can be accepted while it is shown. The worst case is a delete at position 1 of a
// full list, which walks all CAPACITY entries at one store read per cycle. A
// finished result sits in the output register while the next item is accepted;
// a result still waiting there holds the sequencer in its last step.
module positional_list_engine_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // operation[2:0], position[8:3], item_value[40:9], zero fill above
    input  logic [ple_pkg::IN_TDATA-1:0]   i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // fail[0], read_value[32:1], found_position[38:33], count[44:39],
    // is_empty[45], zero fill above
    output logic [ple_pkg::OUT_TDATA-1:0]  o_m_axis_tdata
);

    ple_pkg::t_state r_state, n_state;

    logic [ple_pkg::DATA_W-1:0] r_mem [ple_pkg::CAPACITY];
    logic [ple_pkg::DATA_W-1:0] r_rdata;

    logic                        mem_we, mem_re;
    logic [ple_pkg::IDX_W-1:0]   mem_wa, mem_ra;
    logic [ple_pkg::DATA_W-1:0]  mem_wd;

    logic [ple_pkg::LEN_W-1:0]   r_len, n_len;
    logic [ple_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [ple_pkg::IDX_W-1:0]   r_wa, n_wa;
    logic [ple_pkg::LEN_W-1:0]   r_left, n_left;
    logic                        r_pend, n_pend;
    logic                        r_cap, n_cap;
    logic                        r_first, n_first;
    ple_pkg::t_op                r_op, n_op;
    logic [ple_pkg::POS_W-1:0]   r_pos, n_pos;
    logic signed [ple_pkg::DATA_W-1:0] r_val, n_val;

    logic                        r_fail, n_fail;
    logic [ple_pkg::DATA_W-1:0]  r_rval, n_rval;
    logic [ple_pkg::LEN_W-1:0]   r_found, n_found;

    logic                        r_ovalid, n_ovalid;
    logic [ple_pkg::OUT_TDATA-1:0] r_odata, n_odata;

    logic                        in_acc;
    ple_pkg::t_op                in_op;
    logic [ple_pkg::POS_W-1:0]   in_pos;
    logic signed [ple_pkg::DATA_W-1:0] in_val;
    logic                        out_free;
    logic                        ins_bad, rd_bad;
    logic [ple_pkg::LEN_W:0]     len_p1;
    logic                        loc_hit;

    assign in_op  = ple_pkg::t_op'(i_s_axis_tdata[ple_pkg::OP_W-1:0]);
    assign in_pos = i_s_axis_tdata[ple_pkg::OP_W +: ple_pkg::POS_W];
    assign in_val = i_s_axis_tdata[ple_pkg::OP_W + ple_pkg::POS_W +: ple_pkg::DATA_W];

    assign o_s_axis_tready = (r_state == ple_pkg::ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovalid || i_m_axis_tready;

    assign len_p1  = {1'b0, r_len} + {{ple_pkg::LEN_W{1'b0}}, 1'b1};
    assign ins_bad = (r_len >= ple_pkg::LEN_W'(ple_pkg::CAPACITY)) || (in_pos == '0)
                     || ({1'b0, in_pos} > len_p1);
    assign rd_bad  = (r_len == '0) || (in_pos == '0) || (in_pos > r_len);
    assign loc_hit = r_pend && (r_rdata == r_val);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ple_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        ple_pkg::OP_INSERT: n_state = ins_bad ? ple_pkg::ST_DONE
                                                              : ple_pkg::ST_INS;
                        ple_pkg::OP_DELETE,
                        ple_pkg::OP_GET:    n_state = rd_bad ? ple_pkg::ST_DONE
                                                             : ple_pkg::ST_DEL;
                        ple_pkg::OP_LOCATE: n_state = ple_pkg::ST_LOC;
                        default:            n_state = ple_pkg::ST_DONE;
                    endcase
                end
            end
            ple_pkg::ST_INS: begin
                if (r_left == '0 && !r_pend) n_state = ple_pkg::ST_DONE;
            end
            ple_pkg::ST_DEL: begin
                if (r_left == '0 && !r_pend) n_state = ple_pkg::ST_DONE;
            end
            ple_pkg::ST_LOC: begin
                if (loc_hit || r_left == '0) n_state = ple_pkg::ST_DONE;
            end
            ple_pkg::ST_DONE: begin
                if (out_free) n_state = ple_pkg::ST_IDLE;
            end
            default: n_state = ple_pkg::ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = r_wa;
        mem_wd   = r_rdata;
        mem_re   = 1'b0;
        mem_ra   = r_idx;
        n_len    = r_len;
        n_idx    = r_idx;
        n_wa     = r_wa;
        n_left   = r_left;
        n_pend   = r_pend;
        n_cap    = r_cap;
        n_first  = r_first;
        n_op     = r_op;
        n_pos    = r_pos;
        n_val    = r_val;
        n_fail   = r_fail;
        n_rval   = r_rval;
        n_found  = r_found;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata  = r_odata;

        unique case (r_state)
            ple_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_op    = in_op;
                    n_pos   = in_pos;
                    n_val   = in_val;
                    n_fail  = 1'b0;
                    n_rval  = '0;
                    n_found = '0;
                    n_pend  = 1'b0;
                    n_cap   = 1'b0;
                    n_first = 1'b1;
                    unique case (in_op)
                        ple_pkg::OP_INSERT: begin
                            n_fail = ins_bad;
                            n_idx  = ple_pkg::IDX_W'(r_len - ple_pkg::LEN_W'(1));
                            n_left = ple_pkg::LEN_W'(len_p1 - {1'b0, in_pos});
                        end
                        ple_pkg::OP_DELETE: begin
                            n_fail = rd_bad;
                            n_idx  = ple_pkg::IDX_W'(in_pos - ple_pkg::POS_W'(1));
                            n_left = ple_pkg::LEN_W'(len_p1 - {1'b0, in_pos});
                        end
                        ple_pkg::OP_GET: begin
                            n_fail = rd_bad;
                            n_idx  = ple_pkg::IDX_W'(in_pos - ple_pkg::POS_W'(1));
                            n_left = ple_pkg::LEN_W'(1);
                        end
                        ple_pkg::OP_LOCATE: begin
                            n_idx  = '0;
                            n_left = r_len;
                        end
                        ple_pkg::OP_CLEAR: begin
                            n_len = '0;
                        end
                        default: begin
                            n_fail = 1'b1;
                        end
                    endcase
                end
            end
            // walk downward: read entry k-1, write it to k on the next cycle
            ple_pkg::ST_INS: begin
                if (r_pend) begin
                    mem_we = 1'b1;
                end
                if (r_left != '0) begin
                    mem_re = 1'b1;
                    n_wa   = r_idx + ple_pkg::IDX_W'(1);
                    n_idx  = r_idx - ple_pkg::IDX_W'(1);
                    n_left = r_left - ple_pkg::LEN_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        mem_we = 1'b1;
                        mem_wa = ple_pkg::IDX_W'(r_pos - ple_pkg::POS_W'(1));
                        mem_wd = r_val;
                        n_len  = r_len + ple_pkg::LEN_W'(1);
                    end
                end
            end
            // walk upward: first read is the removed (for get, the read) item, the rest move down one
            ple_pkg::ST_DEL: begin
                if (r_pend) begin
                    if (r_cap) begin
                        n_rval = r_rdata;
                        n_cap  = 1'b0;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
                if (r_left != '0) begin
                    mem_re  = 1'b1;
                    n_wa    = r_idx - ple_pkg::IDX_W'(1);
                    n_idx   = r_idx + ple_pkg::IDX_W'(1);
                    n_left  = r_left - ple_pkg::LEN_W'(1);
                    n_pend  = 1'b1;
                    n_cap   = r_first;
                    n_first = 1'b0;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend && r_op == ple_pkg::OP_DELETE) begin
                        n_len = r_len - ple_pkg::LEN_W'(1);
                    end
                end
            end
            ple_pkg::ST_LOC: begin
                if (loc_hit) begin
                    n_found = ple_pkg::LEN_W'({1'b0, r_wa} + ple_pkg::LEN_W'(1));
                    n_pend  = 1'b0;
                end else if (r_left != '0) begin
                    mem_re = 1'b1;
                    n_wa   = r_idx;
                    n_idx  = r_idx + ple_pkg::IDX_W'(1);
                    n_left = r_left - ple_pkg::LEN_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            ple_pkg::ST_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = ple_pkg::OUT_TDATA'({r_len == '0, r_len, r_found,
                                                     r_rval, r_fail});
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ple_pkg::ST_IDLE;
            r_len    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_wa    <= n_wa;
        r_left  <= n_left;
        r_cap   <= n_cap;
        r_first <= n_first;
        r_op    <= n_op;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_fail  <= n_fail;
        r_rval  <= n_rval;
        r_found <= n_found;
        r_odata <= n_odata;
    end

    // element store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= ple_pkg::LEN_W'(ple_pkg::CAPACITY))
        else $error("list length above capacity");

    a_we_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ple_pkg::ST_INS || r_state == ple_pkg::ST_DEL))
        else $error("store written outside a shift walk");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ple_pkg::ST_IDLE))
        else $error("sequencer idle right after an accepted item");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ple_pkg::ST_DONE)
        else $error("result shown without finishing an item");

    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ple_pkg::ST_IDLE && r_len != n_len)
            |-> (n_len == r_len + ple_pkg::LEN_W'(1) || n_len == r_len - ple_pkg::LEN_W'(1)))
        else $error("length moved by more than one during a walk");

endmodule

/* test/ple_checker.sv */
`timescale 1ns / 1ps

module ple_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_tvalid,
    input  logic                           i_req_tready,
    // operation[2:0], position[8:3], item_value[40:9], zero fill above
    input  logic [ple_pkg::IN_TDATA-1:0]   i_req_tdata,
    input  logic                           i_rsp_tvalid,
    input  logic                           i_rsp_tready,
    // fail[0], read_value[32:1], found_position[38:33], count[44:39],
    // is_empty[45], zero fill above
    input  logic [ple_pkg::OUT_TDATA-1:0]  i_rsp_tdata,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_list_len
);

    typedef struct packed {
        logic                       is_empty;
        logic [ple_pkg::LEN_W-1:0]  count;
        logic [ple_pkg::LEN_W-1:0]  found_pos;
        logic [ple_pkg::DATA_W-1:0] read_value;
        logic                       fail;
    } t_list_result;

    logic [ple_pkg::DATA_W-1:0] shadow_store [ple_pkg::CAPACITY];
    int                         shadow_len = 0;
    t_list_result               expected_q [$];
    int                         mismatch_cnt = 0;

    // applies one request to the shadow list and returns the result it gives
    function automatic t_list_result apply_list_op(
        input logic [ple_pkg::OP_W-1:0]   op,
        input int                         pos,
        input logic [ple_pkg::DATA_W-1:0] val
    );
        t_list_result r;
        int k;
        r = '0;
        case (op)
            ple_pkg::OP_INSERT: begin
                if (shadow_len >= ple_pkg::CAPACITY || pos < 1 || pos > shadow_len + 1) begin
                    r.fail = 1'b1;
                end else begin
                    for (k = shadow_len; k >= pos; k--)
                        shadow_store[k] = shadow_store[k-1];
                    shadow_store[pos-1] = val;
                    shadow_len++;
                end
            end
            ple_pkg::OP_DELETE: begin
                if (pos < 1 || pos > shadow_len) begin
                    r.fail = 1'b1;
                end else begin
                    r.read_value = shadow_store[pos-1];
                    for (k = pos; k < shadow_len; k++)
                        shadow_store[k-1] = shadow_store[k];
                    shadow_len--;
                end
            end
            ple_pkg::OP_GET: begin
                if (pos < 1 || pos > shadow_len)
                    r.fail = 1'b1;
                else
                    r.read_value = shadow_store[pos-1];
            end
            ple_pkg::OP_LOCATE: begin
                // first match wins
                for (k = 0; k < shadow_len; k++)
                    if (r.found_pos == '0 && shadow_store[k] == val)
                        r.found_pos = ple_pkg::LEN_W'(k + 1);
            end
            ple_pkg::OP_CLEAR: begin
                shadow_len = 0;
            end
            default: begin
                r.fail = 1'b1;
            end
        endcase
        r.count    = ple_pkg::LEN_W'(shadow_len);
        r.is_empty = (shadow_len == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_list_result want,
                                   input t_list_result got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display({"%0t mismatch (%s): expected fail=%0b read=%0d found=%0d ",
                      "count=%0d empty=%0b, got fail=%0b read=%0d found=%0d ",
                      "count=%0d empty=%0b"},
                     $realtime, what, want.fail, $signed(want.read_value),
                     want.found_pos, want.count, want.is_empty, got.fail,
                     $signed(got.read_value), got.found_pos, got.count, got.is_empty);
    endtask

    always @(posedge i_clk) begin : watch
        t_list_result got;
        t_list_result want;
        if (i_rst_n) begin
            // results first: an item accepted at this edge cannot have its result yet
            if (i_rsp_tvalid && i_rsp_tready) begin
                got = i_rsp_tdata[ple_pkg::OUT_BITS-1:0];
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.fail !== want.fail || got.read_value !== want.read_value ||
                        got.found_pos !== want.found_pos || got.count !== want.count ||
                        got.is_empty !== want.is_empty)
                        report_mismatch("wrong field", want, got);
                end
            end
            if (i_req_tvalid && i_req_tready)
                expected_q.push_back(apply_list_op(
                    i_req_tdata[ple_pkg::OP_W-1:0],
                    int'(i_req_tdata[ple_pkg::OP_W+ple_pkg::POS_W-1:ple_pkg::OP_W]),
                    i_req_tdata[ple_pkg::IN_BITS-1:ple_pkg::OP_W+ple_pkg::POS_W]));
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_q.size();
        o_list_len   <= shadow_len;
    end

endmodule

/* test/positional_list_engine_core_tb.sv */
`timescale 1ns / 1ps

module positional_list_engine_core_tb;

    localparam int                       RANDOM_ITEMS  = 1825;
    localparam int                       LONG_STALL    = 400;
    localparam int                       CYCLE_LIMIT   = 600000;
    localparam int                       POOL_N        = 12;
    localparam logic [ple_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [ple_pkg::OP_W-1:0] OP_RSVD_MID   = 3'd6;
    localparam logic [ple_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_PROBE} t_mix;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    logic [ple_pkg::IN_TDATA-1:0]  req_data  = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    logic [ple_pkg::OUT_TDATA-1:0] rsp_data;

    int mismatches;
    int pending;
    int list_len;

    int send_idle_pct = 29;
    int recv_idle_pct = 74;
    int stall_req     = 0;

    logic [ple_pkg::DATA_W-1:0] value_pool [POOL_N];

    positional_list_engine_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data)
    );

    ple_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_tvalid (req_valid),
        .i_req_tready (req_ready),
        .i_req_tdata  (req_data),
        .i_rsp_tvalid (rsp_valid),
        .i_rsp_tready (rsp_ready),
        .i_rsp_tdata  (rsp_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_list_len   (list_len)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        int served;
        served = 0;
        forever begin
            @(posedge clk);
            if (stall_req != served) begin
                served = stall_req;
                rsp_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // called at a clock edge; returns at the edge where the item is taken
    task automatic send_item(input logic [ple_pkg::OP_W-1:0]   op,
                             input logic [ple_pkg::POS_W-1:0]  pos,
                             input logic [ple_pkg::DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= {{(ple_pkg::IN_TDATA-ple_pkg::IN_BITS){1'b0}}, val, pos, op};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic send_random(input t_mix mix);
        int len, r, ins_t, del_t, get_t, loc_t;
        logic [ple_pkg::OP_W-1:0]   op;
        logic [ple_pkg::POS_W-1:0]  pos;
        logic [ple_pkg::DATA_W-1:0] val;
        len = list_len;
        case (mix)
            MIX_GROW:     begin ins_t = 70; del_t = 78; get_t = 88; loc_t = 99; end
            MIX_SHRINK:   begin ins_t = 15; del_t = 70; get_t = 85; loc_t = 97; end
            MIX_BALANCED: begin ins_t = 40; del_t = 75; get_t = 87; loc_t = 99; end
            default:      begin ins_t = 20; del_t = 30; get_t = 65; loc_t = 99; end
        endcase
        // pool values make locate hits and duplicates common
        val = ($urandom_range(99) < 60) ? value_pool[$urandom_range(POOL_N-1)] : $urandom();
        if ($urandom_range(99) < 8) begin
            // noise: any op code, any position, any value
            op  = ple_pkg::OP_W'($urandom_range(OP_RSVD_LAST));
            pos = ple_pkg::POS_W'($urandom_range((1 << ple_pkg::POS_W) - 1));
            val = $urandom();
        end else begin
            r   = $urandom_range(99);
            pos = (len == 0) ? ple_pkg::POS_W'(1) : ple_pkg::POS_W'($urandom_range(len, 1));
            if (r < ins_t) begin
                op  = ple_pkg::OP_INSERT;
                pos = ple_pkg::POS_W'($urandom_range(len + 1, 1));
            end else if (r < del_t) begin
                op = ple_pkg::OP_DELETE;
            end else if (r < get_t) begin
                op = ple_pkg::OP_GET;
            end else if (r < loc_t) begin
                op = ple_pkg::OP_LOCATE;
            end else begin
                op = ple_pkg::OP_CLEAR;
            end
        end
        send_item(op, pos, val);
    endtask

    initial begin : stimulus
        int   n, burst, phase;
        t_mix mix;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_N; i++)
            value_pool[i] = $urandom();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, bad positions, extremes, reserved codes
        send_item(ple_pkg::OP_CLEAR,  6'd0,  32'h0);
        send_item(ple_pkg::OP_GET,    6'd1,  32'h0);
        send_item(ple_pkg::OP_DELETE, 6'd1,  32'h0);
        send_item(ple_pkg::OP_LOCATE, 6'd0,  32'h0);
        send_item(ple_pkg::OP_INSERT, 6'd0,  32'h1234_5678);
        send_item(ple_pkg::OP_INSERT, 6'd2,  32'h1234_5678);
        send_item(ple_pkg::OP_INSERT, 6'd1,  32'h7fff_ffff);
        send_item(ple_pkg::OP_INSERT, 6'd1,  32'h8000_0000);
        send_item(ple_pkg::OP_INSERT, 6'd3,  32'hffff_ffff);
        send_item(ple_pkg::OP_INSERT, 6'd63, 32'h5555_aaaa);
        send_item(ple_pkg::OP_GET,    6'd1,  32'h0);
        send_item(ple_pkg::OP_GET,    6'd3,  32'h0);
        send_item(ple_pkg::OP_GET,    6'd4,  32'h0);
        send_item(ple_pkg::OP_GET,    6'd0,  32'h0);
        send_item(ple_pkg::OP_LOCATE, 6'd63, 32'hffff_ffff);
        send_item(ple_pkg::OP_LOCATE, 6'd0,  32'h7fff_ffff);
        send_item(ple_pkg::OP_LOCATE, 6'd1,  32'h0000_0005);
        send_item(OP_RSVD_FIRST,      6'd1,  32'h0);
        send_item(OP_RSVD_MID,        6'd63, 32'hffff_ffff);
        send_item(OP_RSVD_LAST,       6'd2,  32'haaaa_5555);
        send_item(ple_pkg::OP_DELETE, 6'd0,  32'h0);
        send_item(ple_pkg::OP_DELETE, 6'd4,  32'h0);
        send_item(ple_pkg::OP_DELETE, 6'd2,  32'h0);
        send_item(ple_pkg::OP_DELETE, 6'd63, 32'h0);
        send_item(ple_pkg::OP_CLEAR,  6'd63, 32'hffff_ffff);

        n     = 0;
        phase = 1;
        while (n < RANDOM_ITEMS) begin
            if (phase == 1 && n >= RANDOM_ITEMS / 3) begin
                phase         = 2;
                send_idle_pct = 74;
                recv_idle_pct = 29;
            end else if (phase == 2 && n >= 2 * RANDOM_ITEMS / 3) begin
                phase         = 3;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                stall_req++;
            end
            mix   = t_mix'($urandom_range(MIX_PROBE));
            burst = $urandom_range(60, 20);
            // opening burst fills the list to capacity and beyond
            if (n == 0) begin
                mix   = MIX_GROW;
                burst = 60;
            end
            repeat (burst) send_random(mix);
            n += burst;
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2 * ple_pkg::CAPACITY) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
